// ===== src/adsr_envelope_generator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// adsr envelope generator assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ADSR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("adsr assertion failed");
`define ADSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adsr implication failed");
`else
`define ADSR_ASSERT(lbl, cond)
`define ADSR_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// shared widths, codes and types of the adsr envelope generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package adsr_pkg;
  localparam int IDX_W     = 24;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int AMP_W     = 15;
  localparam int PROD_W    = AMP_W + IDX_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam logic [FRAC_W+1:0] FRAC_ONE = (FRAC_W+2)'(1) << FRAC_BITS;
  localparam logic [AMP_W-1:0]  LEVEL_MAX = '1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SUM   = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK        = 3'd6;

  typedef struct packed {
    logic       valid;
    logic [1:0] err;
  } tag_t;
endpackage

// ===== src/adsr_envelope_generator_unit.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// linear attack-decay-sustain-release envelope, one sample per clock
// ----------------------------------------------------------------------------
// usage:
//   a request is taken at each rising edge with start_i high; busy_o is
//   always low, so a new sample index can enter every cycle
//   level_o and error_code_o appear for one cycle with valid_o high,
//   after the stage registers and the divider stages, in request order
//   throughput is one result per clock; each request passes five arithmetic
//   stages and a 15-stage divider that yields one quotient bit per stage
//   configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 note length, 1..4 phase fractions, 5 sustain level, 6 peak);
//   writes must only happen while no request is in flight
//   error 1 when the four fractions do not add to 1.0, error 2 when the
//   index is at or past the note length; level is 0 in both cases
//   reset restores the default note and empties the pipeline; the
//   receiver cannot stall, so no backpressure path exists
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adsr_envelope_generator_unit_macros.svh"
module adsr_envelope_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [adsr_pkg::IDX_W-1:0]     sample_index_i,
  output logic                           valid_o,
  output logic [adsr_pkg::AMP_W-1:0]     level_o,
  output logic [1:0]                     error_code_o,
  input  logic                           cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adsr_pkg::CFG_W-1:0]     cfg_wdata_i
);
  localparam int IW = adsr_pkg::IDX_W;
  localparam int FW = adsr_pkg::FRAC_W;
  localparam int AW = adsr_pkg::AMP_W;

  // configuration registers
  logic [IW-1:0] note_q;
  logic [FW-1:0] att_q, dec_q, hold_q, rel_q, hlev_q;
  logic [AW-1:0] peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_q <= IW'(44100);
      att_q  <= FW'(19661);
      dec_q  <= FW'(13107);
      hold_q <= FW'(19661);
      rel_q  <= FW'(13107);
      hlev_q <= FW'(45875);
      peak_q <= AW'(8192);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adsr_pkg::CFG_NOTE_LENGTH: note_q <= cfg_wdata_i[IW-1:0];
        adsr_pkg::CFG_ATTACK:      att_q  <= cfg_wdata_i[FW-1:0];
        adsr_pkg::CFG_DECAY:       dec_q  <= cfg_wdata_i[FW-1:0];
        adsr_pkg::CFG_HOLD:        hold_q <= cfg_wdata_i[FW-1:0];
        adsr_pkg::CFG_RELEASE:     rel_q  <= cfg_wdata_i[FW-1:0];
        adsr_pkg::CFG_HOLD_LEVEL:  hlev_q <= cfg_wdata_i[FW-1:0];
        adsr_pkg::CFG_PEAK:        peak_q <= cfg_wdata_i[AW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: phase lengths, sustain level, error check
  logic [FW+1:0]       frac_sum;
  logic [IW+FW-1:0]    pa, pd, ph;
  logic [AW+FW-1:0]    psus;
  logic [AW:0]         sus_raw;
  logic [1:0]          err1_d;
  adsr_pkg::tag_t      tag1_q;
  logic [IW-1:0]       t1_q, alen1_q, dlen1_q, hlen1_q;
  logic [AW-1:0]       sus1_q;

  assign frac_sum = (FW+2)'(att_q) + (FW+2)'(dec_q) + (FW+2)'(hold_q) + (FW+2)'(rel_q);
  assign pa       = (IW+FW)'(note_q) * (IW+FW)'(att_q);
  assign pd       = (IW+FW)'(note_q) * (IW+FW)'(dec_q);
  assign ph       = (IW+FW)'(note_q) * (IW+FW)'(hold_q);
  assign psus     = (AW+FW)'(peak_q) * (AW+FW)'(hlev_q);
  assign sus_raw  = psus[adsr_pkg::FRAC_BITS +: AW+1];

  always_comb begin
    priority if (frac_sum != adsr_pkg::FRAC_ONE) begin
      err1_d = adsr_pkg::ERR_SUM;
    end else if (sample_index_i >= note_q) begin
      err1_d = adsr_pkg::ERR_RANGE;
    end else begin
      err1_d = adsr_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else begin
      tag1_q <= '{valid: start_i, err: err1_d};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= sample_index_i;
    alen1_q <= pa[adsr_pkg::FRAC_BITS +: IW];
    dlen1_q <= pd[adsr_pkg::FRAC_BITS +: IW];
    hlen1_q <= ph[adsr_pkg::FRAC_BITS +: IW];
    // sustain saturates when peak times its fraction does not fit in 15 bits
    sus1_q  <= sus_raw[AW] ? adsr_pkg::LEVEL_MAX : sus_raw[AW-1:0];
  end

  // stage 2: phase end positions
  adsr_pkg::tag_t tag2_q;
  logic [IW-1:0]  t2_q, aend2_q, dend2_q, send2_q;
  logic [AW-1:0]  sus2_q;
  logic [IW-1:0]  dend2_d;

  assign dend2_d = alen1_q + dlen1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
    end else begin
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q    <= t1_q;
    aend2_q <= alen1_q;
    dend2_q <= dend2_d;
    send2_q <= dend2_d + hlen1_q;
    sus2_q  <= sus1_q;
  end

  // stage 3: pick the phase and set up operands of the division
  //   attack  : peak * t / a_end
  //   decay   : (peak * (d_end - t) + sus * (t - a_end)) / (d_end - a_end)
  //   sustain : sus / 1
  //   release : sus * (n - t) / (n - s_end)
  adsr_pkg::tag_t tag3_q;
  logic [AW-1:0]  ma3_d, ma3_q, sus3_q;
  logic [IW-1:0]  mb3_d, mb3_q, sb3_d, sb3_q, den3_d, den3_q;

  always_comb begin
    ma3_d  = '0;
    mb3_d  = '0;
    sb3_d  = '0;
    den3_d = IW'(1);
    if (tag2_q.err == adsr_pkg::ERR_NONE) begin
      priority if (t2_q < aend2_q) begin
        ma3_d  = peak_q;
        mb3_d  = t2_q;
        den3_d = aend2_q;
      end else if (t2_q < dend2_q) begin
        ma3_d  = peak_q;
        mb3_d  = dend2_q - t2_q;
        sb3_d  = t2_q - aend2_q;
        den3_d = dend2_q - aend2_q;
      end else if (t2_q < send2_q) begin
        ma3_d  = sus2_q;
        mb3_d  = IW'(1);
      end else begin
        ma3_d  = sus2_q;
        mb3_d  = note_q - t2_q;
        den3_d = note_q - send2_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q <= '0;
    end else begin
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ma3_q  <= ma3_d;
    mb3_q  <= mb3_d;
    sb3_q  <= sb3_d;
    sus3_q <= sus2_q;
    den3_q <= den3_d;
  end

  // stage 4: the two products of the numerator
  adsr_pkg::tag_t               tag4_q;
  logic [adsr_pkg::PROD_W-1:0]  p1_q, p2_q;
  logic [IW-1:0]                den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag4_q <= '0;
    end else begin
      tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= adsr_pkg::PROD_W'(ma3_q) * adsr_pkg::PROD_W'(mb3_q);
    p2_q   <= adsr_pkg::PROD_W'(sus3_q) * adsr_pkg::PROD_W'(sb3_q);
    den4_q <= den3_q;
  end

  // stage 5: numerator sum
  adsr_pkg::tag_t              tag5_q;
  logic [adsr_pkg::NUM_W-1:0]  num5_q;
  logic [IW-1:0]               den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag5_q <= '0;
    end else begin
      tag5_q <= tag4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num5_q <= adsr_pkg::NUM_W'(p1_q) + adsr_pkg::NUM_W'(p2_q);
    den5_q <= den4_q;
  end

  // divider stages, last one is the output register
  adsr_pkg::tag_t tag_out;

  adsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag5_q),
    .num_i  (num5_q),
    .den_i  (den5_q),
    .tag_o  (tag_out),
    .quo_o  (level_o)
  );

  assign valid_o      = tag_out.valid;
  assign error_code_o = tag_out.err;

  // an error result always carries level zero
  `ADSR_ASSERT_IMPL(a_err_zero, valid_o && (error_code_o != adsr_pkg::ERR_NONE), level_o == '0)
  // a sum error only shows while the fractions really miss one
  `ADSR_ASSERT_IMPL(a_sum_err, valid_o && (error_code_o == adsr_pkg::ERR_SUM),
                    frac_sum != adsr_pkg::FRAC_ONE)
  // with sustain at or below the peak, no level exceeds the peak
  `ADSR_ASSERT_IMPL(a_peak_bound,
                    valid_o && (error_code_o == adsr_pkg::ERR_NONE) && (hlev_q <= FW'(65536)),
                    level_o <= peak_q)
endmodule

// ===== src/adsr_div.sv =====
// ----------------------------------------------------------------------------
// adsr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module adsr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  adsr_pkg::tag_t             tag_i,
  input  logic [adsr_pkg::NUM_W-1:0] num_i,
  input  logic [adsr_pkg::IDX_W-1:0] den_i,
  output adsr_pkg::tag_t             tag_o,
  output logic [adsr_pkg::AMP_W-1:0] quo_o
);
  localparam int Stages = adsr_pkg::AMP_W;

  adsr_pkg::tag_t                 tag_q [Stages];
  logic [adsr_pkg::NUM_W-1:0]     rem_q [Stages];
  logic [adsr_pkg::IDX_W-1:0]     den_q [Stages];
  logic [adsr_pkg::AMP_W-1:0]     quo_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int Shift = Stages - 1 - s;
    adsr_pkg::tag_t             tag_in;
    logic [adsr_pkg::NUM_W-1:0] rem_in;
    logic [adsr_pkg::NUM_W-1:0] sub;
    logic [adsr_pkg::IDX_W-1:0] den_in;
    logic [adsr_pkg::AMP_W-1:0] quo_in;
    logic                       take;

    if (s == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sub  = {{(adsr_pkg::NUM_W-adsr_pkg::IDX_W){1'b0}}, den_in} << Shift;
    assign take = (rem_in >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? (rem_in - sub) : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= {quo_in[adsr_pkg::AMP_W-2:0], take};
    end
  end

  assign tag_o = tag_q[Stages-1];
  assign quo_o = quo_q[Stages-1];
endmodule

// ===== verif/adsr_envelope_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit_tb
// drives sample-index requests and register writes into the envelope unit,
// predicts level and error code for every accepted request and compares
// each strobed result in order; random gaps on the request side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// in-order store of predicted envelope results
class envelope_scoreboard;
  // envelope settings mirrored from the register writes
  logic [adsr_pkg::IDX_W-1:0]  note_len;
  logic [adsr_pkg::FRAC_W-1:0] frac_atk, frac_dec, frac_hold, frac_rel, hold_lvl;
  logic [adsr_pkg::AMP_W-1:0]  peak;
  logic [adsr_pkg::AMP_W-1:0]  level_q[$];
  logic [1:0]                  err_q[$];
  int                          mismatches;
  int                          compared;

  function new();
    note_len  = 44100;
    frac_atk  = 19661;
    frac_dec  = 13107;
    frac_hold = 19661;
    frac_rel  = 13107;
    hold_lvl  = 45875;
    peak      = 8192;
  endfunction

  function void write_reg(logic [adsr_pkg::CFG_IDX_W-1:0] idx, logic [adsr_pkg::CFG_W-1:0] d);
    case (idx)
      adsr_pkg::CFG_NOTE_LENGTH: note_len  = d[adsr_pkg::IDX_W-1:0];
      adsr_pkg::CFG_ATTACK:      frac_atk  = d[adsr_pkg::FRAC_W-1:0];
      adsr_pkg::CFG_DECAY:       frac_dec  = d[adsr_pkg::FRAC_W-1:0];
      adsr_pkg::CFG_HOLD:        frac_hold = d[adsr_pkg::FRAC_W-1:0];
      adsr_pkg::CFG_RELEASE:     frac_rel  = d[adsr_pkg::FRAC_W-1:0];
      adsr_pkg::CFG_HOLD_LEVEL:  hold_lvl  = d[adsr_pkg::FRAC_W-1:0];
      adsr_pkg::CFG_PEAK:        peak      = d[adsr_pkg::AMP_W-1:0];
      default: ;
    endcase
  endfunction

  // expected level and error code for one sample index
  function void note_request(logic [adsr_pkg::IDX_W-1:0] t);
    longint unsigned n, a_end, d_end, s_end, sus, len, d, sum, lvl;
    logic [1:0] err;
    n   = note_len;
    sum = longint'(frac_atk) + frac_dec + frac_hold + frac_rel;
    lvl = 0;
    if (sum != (64'd1 << adsr_pkg::FRAC_BITS)) err = adsr_pkg::ERR_SUM;
    else if (t >= note_len) err = adsr_pkg::ERR_RANGE;
    else begin
      err   = adsr_pkg::ERR_NONE;
      a_end = (n * frac_atk) >> adsr_pkg::FRAC_BITS;
      d_end = a_end + ((n * frac_dec) >> adsr_pkg::FRAC_BITS);
      s_end = d_end + ((n * frac_hold) >> adsr_pkg::FRAC_BITS);
      sus   = (longint'(peak) * hold_lvl) >> adsr_pkg::FRAC_BITS;
      if (sus > 32767) sus = 32767;
      if (t < a_end) lvl = (longint'(peak) * t) / a_end;
      else if (t < d_end) begin
        len = d_end - a_end;
        d   = t - a_end;
        lvl = (longint'(peak) * (len - d) + sus * d) / len;
      end else if (t < s_end) lvl = sus;
      else begin
        len = n - s_end;
        d   = t - s_end;
        lvl = (sus * (len - d)) / len;
      end
    end
    level_q.push_back(lvl[adsr_pkg::AMP_W-1:0]);
    err_q.push_back(err);
  endfunction

  function int pending();
    return level_q.size();
  endfunction

  task report(string what);
    mismatches++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task check_result(logic [adsr_pkg::AMP_W-1:0] lvl, logic [1:0] err);
    logic [adsr_pkg::AMP_W-1:0] exp_lvl;
    logic [1:0]                 exp_err;
    if (level_q.size() == 0) begin
      report("result with no request outstanding");
    end else begin
      exp_lvl = level_q.pop_front();
      exp_err = err_q.pop_front();
      compared++;
      if (lvl !== exp_lvl)
        report($sformatf("level got %0d expected %0d", lvl, exp_lvl));
      if (err !== exp_err)
        report($sformatf("error code got %0d expected %0d", err, exp_err));
    end
  endtask
endclass

module adsr_envelope_generator_unit_tb;
  localparam int LATENCY   = 20;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1930;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 start_i = 1'b0;
  logic                                 busy_o;
  logic [adsr_pkg::IDX_W-1:0]           sample_index_i = '0;
  logic                                 valid_o;
  logic [adsr_pkg::AMP_W-1:0]           level_o;
  logic [1:0]                           error_code_o;
  logic                                 cfg_we_i = 1'b0;
  logic [adsr_pkg::CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [adsr_pkg::CFG_W-1:0]           cfg_wdata_i = '0;

  envelope_scoreboard env_sb = new();
  int idle_pct;              // chance of a gap before each request, in percent
  int idle_cycles = 0;       // watchdog: cycles since a request was accepted or a result seen
  bit timed_out = 1'b0;
  int err_seen[3];           // error codes observed, for the summary

  always #2 clk_i = ~clk_i;

  adsr_envelope_generator_unit u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .sample_index_i, .valid_o, .level_o,
    .error_code_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // note accepted requests and check strobed results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        env_sb.note_request(sample_index_i);
      end
      if (valid_o) begin
        env_sb.check_result(level_o, error_code_o);
        if (error_code_o < 3) err_seen[error_code_o]++;
      end
      if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: no request accepted and no result seen for too long ends the run
  always @(posedge clk_i) begin
    if (idle_cycles > WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results outstanding", env_sb.pending());
      $display("adsr_envelope_generator_unit test failed");
      $finish;
    end
  end

  // one request, held until accepted, with an optional random gap first
  task send_sample(logic [adsr_pkg::IDX_W-1:0] t);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    sample_index_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (env_sb.pending() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // register write only while the pipeline is empty
  task write_cfg(logic [adsr_pkg::CFG_IDX_W-1:0] idx, logic [adsr_pkg::CFG_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    env_sb.write_reg(idx, d);
  endtask

  task set_envelope(int n, int a, int d, int h, int r, int lvl, int pk);
    write_cfg(adsr_pkg::CFG_NOTE_LENGTH, adsr_pkg::CFG_W'(n));
    write_cfg(adsr_pkg::CFG_ATTACK, adsr_pkg::CFG_W'(a));
    write_cfg(adsr_pkg::CFG_DECAY, adsr_pkg::CFG_W'(d));
    write_cfg(adsr_pkg::CFG_HOLD, adsr_pkg::CFG_W'(h));
    write_cfg(adsr_pkg::CFG_RELEASE, adsr_pkg::CFG_W'(r));
    write_cfg(adsr_pkg::CFG_HOLD_LEVEL, adsr_pkg::CFG_W'(lvl));
    write_cfg(adsr_pkg::CFG_PEAK, adsr_pkg::CFG_W'(pk));
  endtask

  // random envelope; shares mostly sum to 1.0, sometimes not
  task random_envelope();
    int n, a, d, h, r;
    case ($urandom_range(3))
      0: n = $urandom_range(1, 64);
      1: n = $urandom_range(1, 5000);
      2: n = $urandom_range(1, 2 ** 24 - 1);
      default: n = 2 ** 24 - 1;
    endcase
    a = $urandom_range(65536);
    d = $urandom_range(65536 - a);
    h = $urandom_range(65536 - a - d);
    r = 65536 - a - d - h;
    if ($urandom_range(9) == 0) r = $urandom_range(65536);
    set_envelope(n, a, d, h, r, $urandom_range(131071), $urandom_range(32767));
  endtask

  // index mostly inside the note, sometimes past it, any 24-bit value now and then
  task random_burst(int count);
    logic [adsr_pkg::IDX_W-1:0] t;
    repeat (count) begin
      case ($urandom_range(9))
        0: t = adsr_pkg::IDX_W'($urandom());
        1: t = adsr_pkg::IDX_W'(env_sb.note_len + $urandom_range(3));
        2: t = env_sb.note_len - 1'b1;
        default: t = (env_sb.note_len == 0) ? '0 :
                     adsr_pkg::IDX_W'($urandom_range(env_sb.note_len - 1'b1));
      endcase
      send_sample(t);
    end
  endtask

  initial begin
    int sent;
    idle_pct    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset envelope across all phases and the note edges
    send_sample(0);
    send_sample(1);
    send_sample(13229);
    send_sample(13230);
    send_sample(22050);
    send_sample(35280);
    send_sample(44099);
    send_sample(44100);
    send_sample('1);
    drain();
    // attack-only note at full peak, sustain fraction set above one
    set_envelope(100, 65536, 0, 0, 0, 131071, 32767);
    send_sample(0);
    send_sample(50);
    send_sample(99);
    send_sample(100);
    drain();
    // no attack, decay flat at the saturated sustain, no hold before release
    set_envelope(2 ** 24 - 1, 0, 32768, 0, 32768, 131071, 32767);
    send_sample(0);
    send_sample(8388606);
    send_sample(8388608);
    send_sample(2 ** 24 - 2);
    drain();
    // shares not summing to one, checked before range; zero peak
    set_envelope(1, 65535, 0, 0, 0, 0, 0);
    send_sample(0);
    send_sample('1);
    drain();
    write_cfg(adsr_pkg::CFG_RELEASE, adsr_pkg::CFG_W'(1));
    send_sample(0);
    send_sample(5);
    drain();

    // random phases: light sender gaps, heavy sender gaps, then none
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent < N_RANDOM / 3) idle_pct = 38;
      else if (sent < 2 * N_RANDOM / 3) idle_pct = 70;
      else idle_pct = 0;
      random_envelope();
      random_burst(40);
      sent += 40;
      drain();
    end

    $display("checked %0d results over %0d envelope settings", env_sb.compared,
             (N_RANDOM + 39) / 40 + 4);
    $display("error codes seen: none %0d, share sum %0d, range %0d",
             err_seen[0], err_seen[1], err_seen[2]);
    if (env_sb.mismatches == 0 && env_sb.pending() == 0)
      $display("adsr_envelope_generator_unit test passed");
    else
      $display("adsr_envelope_generator_unit test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/adsr_pkg.sv
src/adsr_div.sv
src/adsr_envelope_generator_unit.sv
verif/adsr_envelope_generator_unit_tb.sv
